FILE: src/skhp_pkg.sv
package skhp_pkg;

  localparam int unsigned KickLenW  = 10;
  localparam int unsigned DutyW     = 7;
  localparam int unsigned KickCntW  = 11;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 8;

  localparam logic [KickLenW-1:0] KickLengthRst = 10'd400;
  localparam logic [DutyW-1:0]    KickDutyRst   = 7'd100;
  localparam logic [DutyW-1:0]    HoldDutyRst   = 7'd5;
  localparam logic [DutyW-1:0]    PwmPeriodRst  = 7'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KICK_LENGTH = 2'd0,
    CFG_KICK_DUTY   = 2'd1,
    CFG_HOLD_DUTY   = 2'd2,
    CFG_PWM_PERIOD  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_KICK = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  localparam logic [PhaseW-1:0] PhaseIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhaseKick = 2'd1;
  localparam logic [PhaseW-1:0] PhaseHold = 2'd2;

endpackage

FILE: src/solenoid_kick_hold_pwm_top.sv
// channel   | dir | tdata fields (lsb first)                      | tuser | tlast
// s_axis    | in  | button_released[0], stroke_end_active[1], pad  | -     | -
// m_axis    | out | coil_on[0], phase[2:1], pad                     | -     | -
// cfg       | in  | cfg_we_i, cfg_idx_i (register index), cfg_data_i | -     | -
//
// one tick per clock unless stalled: controller state and pwm counter advance in the
// cycle a tick is taken and the result lands in the output register
// a new tick is taken while the output register is empty or being drained
// reset (rst_ni low, asynchronous) returns to idle with the registers at defaults
// when m_axis stalls with a result held, s_axis stalls too
module solenoid_kick_hold_pwm_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // button_released, stroke_end_active, zero pad
  input  logic [skhp_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // coil_on, phase, zero pad
  output logic [skhp_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [skhp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [skhp_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [skhp_pkg::KickLenW-1:0] kick_length_q;
  logic [skhp_pkg::DutyW-1:0]    kick_duty_q;
  logic [skhp_pkg::DutyW-1:0]    hold_duty_q;
  logic [skhp_pkg::DutyW-1:0]    pwm_period_q;

  skhp_pkg::state_e              state_q, state_d;
  logic [skhp_pkg::DutyW-1:0]    duty_q, duty_d;
  logic [skhp_pkg::KickCntW-1:0] kick_cnt_q, kick_cnt_d;
  logic [skhp_pkg::DutyW-1:0]    pwm_cnt_q, pwm_cnt_d;

  logic                          out_valid_q;
  logic                          coil_q, coil_d;
  logic [skhp_pkg::PhaseW-1:0]   phase_q, phase_d;

  logic                          accept;
  logic                          released;
  logic                          stroke_end;
  logic                          pwm_clr;
  logic [skhp_pkg::DutyW-1:0]    pwm_base;
  logic [skhp_pkg::DutyW:0]      pwm_inc;

  assign released   = s_axis_tdata[0];
  assign stroke_end = s_axis_tdata[1];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_length_q <= skhp_pkg::KickLengthRst;
      kick_duty_q   <= skhp_pkg::KickDutyRst;
      hold_duty_q   <= skhp_pkg::HoldDutyRst;
      pwm_period_q  <= skhp_pkg::PwmPeriodRst;
    end else if (cfg_we_i) begin
      case (skhp_pkg::cfg_idx_e'(cfg_idx_i))
        skhp_pkg::CFG_KICK_LENGTH: kick_length_q <= cfg_data_i[skhp_pkg::KickLenW-1:0];
        skhp_pkg::CFG_KICK_DUTY:   kick_duty_q   <= cfg_data_i[skhp_pkg::DutyW-1:0];
        skhp_pkg::CFG_HOLD_DUTY:   hold_duty_q   <= cfg_data_i[skhp_pkg::DutyW-1:0];
        skhp_pkg::CFG_PWM_PERIOD:  pwm_period_q  <= cfg_data_i[skhp_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  // phase update
  always_comb begin
    state_d    = state_q;
    duty_d     = duty_q;
    kick_cnt_d = kick_cnt_q;
    pwm_clr    = 1'b0;
    phase_d    = skhp_pkg::PhaseIdle;
    if (released) begin
      state_d = skhp_pkg::ST_IDLE;
      duty_d  = '0;
      pwm_clr = 1'b1;
    end else begin
      case (state_q)
        skhp_pkg::ST_IDLE: begin
          state_d    = skhp_pkg::ST_KICK;
          duty_d     = kick_duty_q;
          kick_cnt_d = '0;
        end
        skhp_pkg::ST_KICK: begin
          if (kick_cnt_q <= {1'b0, kick_length_q}) begin
            kick_cnt_d = kick_cnt_q + 1'b1;
          end else begin
            state_d = skhp_pkg::ST_HOLD;
            duty_d  = hold_duty_q;
          end
        end
        skhp_pkg::ST_HOLD: begin
          if (!stroke_end) begin
            state_d    = skhp_pkg::ST_KICK;
            duty_d     = kick_duty_q;
            kick_cnt_d = '0;
          end
        end
        default: begin
          state_d = skhp_pkg::ST_IDLE;
          duty_d  = '0;
          pwm_clr = 1'b1;
        end
      endcase
    end

    case (state_d)
      skhp_pkg::ST_KICK: phase_d = skhp_pkg::PhaseKick;
      skhp_pkg::ST_HOLD: phase_d = skhp_pkg::PhaseHold;
      default:           phase_d = skhp_pkg::PhaseIdle;
    endcase
  end

  // software pwm
  always_comb begin
    pwm_base = pwm_clr ? '0 : pwm_cnt_q;
    coil_d   = pwm_base < duty_d;
    pwm_inc  = {1'b0, pwm_base} + 1'b1;
    if (pwm_inc >= {1'b0, pwm_period_q}) begin
      pwm_cnt_d = '0;
    end else begin
      pwm_cnt_d = pwm_inc[skhp_pkg::DutyW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= skhp_pkg::ST_IDLE;
      duty_q     <= '0;
      kick_cnt_q <= '0;
      pwm_cnt_q  <= '0;
    end else if (accept) begin
      state_q    <= state_d;
      duty_q     <= duty_d;
      kick_cnt_q <= kick_cnt_d;
      pwm_cnt_q  <= pwm_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      coil_q  <= coil_d;
      phase_q <= phase_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(skhp_pkg::OutDataW - skhp_pkg::PhaseW - 1){1'b0}}, phase_q, coil_q};

endmodule

FILE: tb/tb_solenoid_kick_hold_pwm_top.sv
module tb_solenoid_kick_hold_pwm_top;
  import skhp_pkg::*;

  typedef struct packed {
    logic              coil;
    logic [PhaseW-1:0] phase;
  } coil_res_t;

  typedef struct {
    logic              is_cfg;
    cfg_idx_e          idx;
    logic [CfgDataW-1:0] val;
    logic              rel;
    logic              stroke;
    logic              typed;
    logic              coil;
    logic [PhaseW-1:0] phase;
  } dir_row_t;

  localparam int NumDir = 26;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  cfg_idx_e            cfg_idx_i = CFG_KICK_LENGTH;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic no_gaps = 1'b0;
  int   mismatch_cnt = 0;

  coil_res_t coil_expect_q[$];

  // predictor copy of registers and controller state
  logic [KickLenW-1:0] kick_len_q  = KickLengthRst;
  logic [DutyW-1:0]    kick_duty_q = KickDutyRst;
  logic [DutyW-1:0]    hold_duty_q = HoldDutyRst;
  logic [DutyW-1:0]    period_q    = PwmPeriodRst;
  logic [PhaseW-1:0]   ph_q        = PhaseIdle;
  logic [DutyW-1:0]    duty_q      = '0;
  logic [KickCntW-1:0] kick_cnt_q  = '0;
  logic [DutyW-1:0]    pwm_cnt_q   = '0;

  dir_row_t dir_tab [NumDir] = '{
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b1, 1'b0, 1'b1, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b1, 1'b1, 1'b1, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b1, 1'b1, PhaseKick},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b1, 1'b1, PhaseKick},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b1, 1'b1, 1'b1, 1'b0, PhaseIdle},
    '{1'b1, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b1, CFG_KICK_DUTY,   10'd127,  1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b1, CFG_HOLD_DUTY,   10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b1, CFG_PWM_PERIOD,  10'd1,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b1, 1'b1, PhaseKick},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b1, 1'b0, PhaseHold},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b1, 1'b0, 1'b1, 1'b0, PhaseIdle},
    '{1'b1, CFG_PWM_PERIOD,  10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b1, CFG_HOLD_DUTY,   10'd127,  1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b1, CFG_KICK_DUTY,   10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b0, 1'b1, 1'b0, 1'b0, PhaseIdle},
    '{1'b0, CFG_KICK_LENGTH, 10'd0,    1'b1, 1'b1, 1'b1, 1'b0, PhaseIdle}
  };

  solenoid_kick_hold_pwm_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("solenoid_kick_hold_pwm_top: mismatch");
    $finish;
  end

  function automatic coil_res_t coil_tick(logic rel, logic stroke);
    coil_res_t res;
    logic [DutyW:0] nxt;
    if (rel) begin
      ph_q = PhaseIdle;
      duty_q = '0;
      pwm_cnt_q = '0;
    end else begin
      case (ph_q)
        PhaseIdle: begin
          ph_q = PhaseKick;
          duty_q = kick_duty_q;
          kick_cnt_q = '0;
        end
        PhaseKick: begin
          if (kick_cnt_q <= {1'b0, kick_len_q}) begin
            kick_cnt_q = kick_cnt_q + 1'b1;
          end else begin
            ph_q = PhaseHold;
            duty_q = hold_duty_q;
          end
        end
        PhaseHold: begin
          if (!stroke) begin
            ph_q = PhaseKick;
            duty_q = kick_duty_q;
            kick_cnt_q = '0;
          end
        end
        default: begin
          ph_q = PhaseIdle;
          duty_q = '0;
          pwm_cnt_q = '0;
        end
      endcase
    end
    res.coil = pwm_cnt_q < duty_q;
    res.phase = ph_q;
    nxt = {1'b0, pwm_cnt_q} + 1'b1;
    if (nxt >= {1'b0, period_q}) nxt = '0;
    pwm_cnt_q = nxt[DutyW-1:0];
    return res;
  endfunction

  task automatic drive_tick(input logic rel, input logic stroke, input logic typed,
                            input logic t_coil, input logic [PhaseW-1:0] t_phase);
    coil_res_t pred;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW-2){1'b0}}, stroke, rel};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = coil_tick(rel, stroke);
    if (typed) begin
      pred.coil = t_coil;
      pred.phase = t_phase;
    end
    coil_expect_q.push_back(pred);
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (coil_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    drain_outputs();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_KICK_LENGTH: kick_len_q = val[KickLenW-1:0];
      CFG_KICK_DUTY:   kick_duty_q = val[DutyW-1:0];
      CFG_HOLD_DUTY:   hold_duty_q = val[DutyW-1:0];
      default:         period_q = val[DutyW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // press runs with the stroke switch mostly closed, mixed with noise
  task automatic run_presses(input int n_ticks, input int min_press, input int max_press);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_ticks) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 3);
        repeat (len) drive_tick(1'b1, 1'($urandom_range(1)), 1'b0, 1'b0, PhaseIdle);
        cnt += len;
        len = $urandom_range(min_press, max_press);
        repeat (len) drive_tick(1'b0, $urandom_range(99) >= 12, 1'b0, 1'b0, PhaseIdle);
        cnt += len;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) drive_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, 1'b0,
                                PhaseIdle);
        cnt += len;
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    coil_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (coil_expect_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual tdata %h", $time, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = coil_expect_q.pop_front();
        if (m_axis_tdata[0] !== want.coil) begin
          $display("%0t: coil_on expected %0d actual %0d", $time, want.coil, m_axis_tdata[0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[PhaseW:1] !== want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, want.phase,
                   m_axis_tdata[PhaseW:1]);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int kl;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        drive_tick(dir_tab[i].rel, dir_tab[i].stroke, dir_tab[i].typed,
                   dir_tab[i].coil, dir_tab[i].phase);
      end
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(CFG_KICK_LENGTH, 10'd0);
          write_reg(CFG_KICK_DUTY, 10'd127);
          write_reg(CFG_HOLD_DUTY, 10'd0);
          write_reg(CFG_PWM_PERIOD, 10'd1);
          run_presses(110, 1, 20);
        end
        1: begin
          // longest kick, then hold
          write_reg(CFG_KICK_LENGTH, 10'd1023);
          write_reg(CFG_KICK_DUTY, 10'd0);
          write_reg(CFG_HOLD_DUTY, 10'd127);
          write_reg(CFG_PWM_PERIOD, 10'd127);
          run_presses(1040, 1030, 1060);
        end
        2: begin
          write_reg(CFG_KICK_LENGTH, 10'd3);
          write_reg(CFG_KICK_DUTY, 10'd127);
          write_reg(CFG_HOLD_DUTY, 10'd127);
          write_reg(CFG_PWM_PERIOD, 10'd0);
          run_presses(110, 1, 30);
        end
        default: begin
          kl = $urandom_range(0, 40);
          no_gaps = (p == 4);
          write_reg(CFG_KICK_LENGTH, 10'(kl));
          write_reg(CFG_KICK_DUTY, 10'($urandom_range(0, 127)));
          write_reg(CFG_HOLD_DUTY, 10'($urandom_range(0, 127)));
          write_reg(CFG_PWM_PERIOD,
                    10'($urandom_range(1) ? $urandom_range(1, 20) : $urandom_range(1, 127)));
          run_presses(110, 1, 3 * kl + 20);
        end
      endcase
    end
    no_gaps = 1'b0;

    drain_outputs();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("solenoid_kick_hold_pwm_top: match");
    end else begin
      $display("solenoid_kick_hold_pwm_top: mismatch");
    end
    $finish;
  end

endmodule
